/* hdl/vps_pkg.sv */
// ----------------------------------------------------------------------------
// vps_pkg: shared types and constants for the vibration pattern sequencer
// Transfer payloads, request and opcode codes, sequencer states and the
// byte image of the seven built-in rumble patterns.
// ----------------------------------------------------------------------------
`default_nettype none

package vps_pkg;

   localparam logic [1:0] REQ_TICK    = 2'd0;
   localparam logic [1:0] REQ_TRIGGER = 2'd1;
   localparam logic [1:0] REQ_STOP    = 2'd2;

   localparam logic [7:0] OP_END   = 8'd0;
   localparam logic [7:0] OP_ON    = 8'd1;
   localparam logic [7:0] OP_OFF   = 8'd2;
   localparam logic [7:0] OP_VAR   = 8'd3;
   localparam logic [7:0] OP_DELAY = 8'd4;

   localparam logic CSR_FORCE_FEEDBACK = 1'b0;
   localparam logic CSR_DEMO_PLAYBACK  = 1'b1;

   localparam int unsigned IMAGE_LEN      = 56;
   localparam int unsigned IMAGE_PATTERNS = 7;

   localparam logic [7:0] ROM_IMAGE [IMAGE_LEN] = '{
      8'd1, 8'd4, 8'd20, 8'd2, 8'd3, 8'd0, 8'd0,
      8'd3, 8'd150, 8'd4, 8'd8, 8'd3, 8'd0, 8'd0,
      8'd3, 8'd120, 8'd4, 8'd8, 8'd3, 8'd0, 8'd0,
      8'd3, 8'd64, 8'd1, 8'd4, 8'd10, 8'd2, 8'd3, 8'd0, 8'd0,
      8'd3, 8'd255, 8'd4, 8'd32, 8'd3, 8'd0, 8'd0,
      8'd3, 8'd0, 8'd2, 8'd3, 8'd0, 8'd2, 8'd3, 8'd0, 8'd2, 8'd0,
      8'd3, 8'd100, 8'd1, 8'd4, 8'd10, 8'd2, 8'd3, 8'd0, 8'd0
   };

   localparam int unsigned PATTERN_START [IMAGE_PATTERNS] = '{0, 7, 14, 21, 30, 37, 47};

   typedef struct packed {
      logic [1:0] req_type;
      logic [2:0] profile_index;
   } req_item_type;

   typedef struct packed {
      logic       motor_on;
      logic [7:0] motor_level;
      logic       pattern_running;
   } rsp_item_type;

   typedef struct packed {
      logic reg_index;
      logic reg_data;
   } csr_item_type;

   typedef enum logic [2:0] {
      ST_FILL,
      ST_IDLE,
      ST_OP_READ,
      ST_OP,
      ST_ARG_READ,
      ST_ARG,
      ST_DONE
   } state_type;

   function automatic logic [7:0] image_byte(input logic [15:0] addr);
      logic [7:0] b;
      b = 8'd0;
      if (32'(addr) < IMAGE_LEN) begin
         b = ROM_IMAGE[addr[5:0]];
      end
      return b;
   endfunction

endpackage

`default_nettype wire

/* hdl/vps_stream_if.sv */
// ----------------------------------------------------------------------------
// vps_stream_if: valid/ready channel
// One transfer takes place at a rising edge with valid and ready both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface vps_stream_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* hdl/vps_ram.sv */
// ----------------------------------------------------------------------------
// vps_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module vps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* hdl/vibration_pattern_sequencer.sv */
// ----------------------------------------------------------------------------
// vibration_pattern_sequencer: rumble pattern player for one pad
// Plays byte-coded motor patterns from a pattern RAM, one opcode at a time.
// ----------------------------------------------------------------------------
// Usage:
//   req_if carries tick, trigger and stop requests; rsp_if returns one
//   result per request: motor on flag, motor level and pattern running.
//   csr_if writes force_feedback_on (index 0) and demo_playback_active
//   (index 1); it is always ready.
// Reset: state clears but for budget_ff, arg_delay_ff and rsp_ff; a load
//   pass writes the pattern image into the RAM while req_if is not ready.
// Sequence: a trigger, stop or tick that runs no opcodes goes from IDLE
//   to DONE, which loads the result register. A tick that reaches zero
//   walks the pattern through the one read port of the pattern RAM: OP_READ
//   and OP per ON, OFF or stopping code, also ARG_READ and ARG per VAR or
//   DELAY, at most ROM_DEPTH+1 opcodes, then DONE.
// Throughput: one request at a time; the next one is taken as soon as the
//   result sits in the output register.
// Stall: while rsp_if is not ready the result is held; one more request is
//   processed and waits internally, then req_if stops.
// ----------------------------------------------------------------------------
`default_nettype none

module vibration_pattern_sequencer #(
   parameter int ROM_DEPTH    = 64,
   parameter int NUM_PATTERNS = 7
) (
   input wire logic    clock,
   input wire logic    reset,
   vps_stream_if.sink   req_if,
   vps_stream_if.source rsp_if,
   vps_stream_if.sink   csr_if
);

   localparam int AW = $clog2(ROM_DEPTH);
   localparam int BW = $clog2(ROM_DEPTH + 2);
   localparam logic [AW-1:0] LAST_ADDR   = AW'(ROM_DEPTH - 1);
   localparam logic [BW-1:0] BUDGET_INIT = BW'(ROM_DEPTH + 1);

   vps_pkg::state_type state_ff, state_in;

   logic          ff_on_ff, demo_ff;
   logic [AW-1:0] fill_addr_ff, fill_addr_in;
   logic [AW-1:0] ptr_ff, ptr_in, ptr_inc;
   logic          active_ff, active_in;
   logic [7:0]    tick_ff, tick_in, tick_dec;
   logic          on_ff, on_in;
   logic [7:0]    level_ff, level_in;
   logic [BW-1:0] budget_ff, budget_in, budget_dec;
   logic          arg_delay_ff, arg_delay_in;
   logic          rsp_valid_ff, rsp_valid_in;
   vps_pkg::rsp_item_type rsp_ff, rsp_in;

   logic          req_fire, rsp_load, trig_ok;
   logic [7:0]    rd_data;
   logic [AW-1:0] start_tab [8];
   vps_pkg::req_item_type req;

   for (genvar g = 0; g < 8; g++) begin : g_start
      if (g < vps_pkg::IMAGE_PATTERNS) begin : g_used
         localparam int unsigned S = vps_pkg::PATTERN_START[g] % ROM_DEPTH;
         assign start_tab[g] = AW'(S);
      end else begin : g_unused
         assign start_tab[g] = '0;
      end
   end

   vps_ram #(
      .WIDTH (8),
      .DEPTH (ROM_DEPTH)
   ) u_pattern_ram (
      .clock   (clock),
      .wr_en   (state_ff == vps_pkg::ST_FILL),
      .wr_addr (fill_addr_ff),
      .wr_data (vps_pkg::image_byte(16'(fill_addr_ff))),
      .rd_addr (ptr_ff),
      .rd_data (rd_data)
   );

   assign req         = req_if.payload;
   assign req_if.ready = (state_ff == vps_pkg::ST_IDLE);
   assign req_fire    = req_if.valid && req_if.ready;
   assign csr_if.ready = 1'b1;
   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.payload = rsp_ff;

   assign ptr_inc    = (ptr_ff == LAST_ADDR) ? '0 : ptr_ff + 1'b1;
   assign tick_dec   = tick_ff - 8'd1;
   assign budget_dec = budget_ff - 1'b1;
   assign trig_ok    = ff_on_ff && !demo_ff
                       && (32'(req.profile_index) < NUM_PATTERNS)
                       && (32'(req.profile_index) < vps_pkg::IMAGE_PATTERNS);
   assign rsp_load   = (state_ff == vps_pkg::ST_DONE) && (!rsp_valid_ff || rsp_if.ready);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         vps_pkg::ST_FILL: begin
            if (fill_addr_ff == LAST_ADDR) begin
               state_in = vps_pkg::ST_IDLE;
            end
         end
         vps_pkg::ST_IDLE: begin
            if (req_fire) begin
               if (req.req_type == vps_pkg::REQ_TICK && active_ff && tick_dec == 8'd0) begin
                  state_in = vps_pkg::ST_OP_READ;
               end else begin
                  state_in = vps_pkg::ST_DONE;
               end
            end
         end
         vps_pkg::ST_OP_READ: state_in = vps_pkg::ST_OP;
         vps_pkg::ST_OP: begin
            case (rd_data)
               vps_pkg::OP_ON, vps_pkg::OP_OFF: begin
                  state_in = (budget_dec != '0) ? vps_pkg::ST_OP_READ : vps_pkg::ST_DONE;
               end
               vps_pkg::OP_VAR, vps_pkg::OP_DELAY: state_in = vps_pkg::ST_ARG_READ;
               default: state_in = vps_pkg::ST_DONE;
            endcase
         end
         vps_pkg::ST_ARG_READ: state_in = vps_pkg::ST_ARG;
         vps_pkg::ST_ARG: begin
            if (arg_delay_ff || budget_ff == '0) begin
               state_in = vps_pkg::ST_DONE;
            end else begin
               state_in = vps_pkg::ST_OP_READ;
            end
         end
         vps_pkg::ST_DONE: begin
            if (rsp_load) begin
               state_in = vps_pkg::ST_IDLE;
            end
         end
         default: state_in = vps_pkg::ST_IDLE;
      endcase
   end

   // datapath
   always_comb begin
      fill_addr_in = fill_addr_ff;
      ptr_in       = ptr_ff;
      active_in    = active_ff;
      tick_in      = tick_ff;
      on_in        = on_ff;
      level_in     = level_ff;
      budget_in    = budget_ff;
      arg_delay_in = arg_delay_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         vps_pkg::ST_FILL: begin
            fill_addr_in = fill_addr_ff + 1'b1;
         end
         vps_pkg::ST_IDLE: begin
            if (req_fire) begin
               case (req.req_type)
                  vps_pkg::REQ_TICK: begin
                     if (active_ff) begin
                        tick_in   = tick_dec;
                        budget_in = BUDGET_INIT;
                     end
                  end
                  vps_pkg::REQ_TRIGGER: begin
                     if (trig_ok) begin
                        ptr_in    = start_tab[req.profile_index];
                        active_in = 1'b1;
                        tick_in   = 8'd1;
                     end
                  end
                  vps_pkg::REQ_STOP: begin
                     on_in     = 1'b0;
                     level_in  = 8'd0;
                     active_in = 1'b0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         vps_pkg::ST_OP: begin
            ptr_in    = ptr_inc;
            budget_in = budget_dec;
            case (rd_data)
               vps_pkg::OP_END: begin
                  active_in = 1'b0;
                  on_in     = 1'b0;
                  level_in  = 8'd0;
               end
               vps_pkg::OP_ON:    on_in = 1'b1;
               vps_pkg::OP_OFF:   on_in = 1'b0;
               vps_pkg::OP_VAR:   arg_delay_in = 1'b0;
               vps_pkg::OP_DELAY: arg_delay_in = 1'b1;
               default: begin
               end
            endcase
         end
         vps_pkg::ST_ARG: begin
            ptr_in = ptr_inc;
            if (arg_delay_ff) begin
               tick_in = rd_data;
            end else begin
               level_in = rd_data;
            end
         end
         vps_pkg::ST_DONE: begin
            if (rsp_load) begin
               rsp_in.motor_on        = on_ff;
               rsp_in.motor_level     = level_ff;
               rsp_in.pattern_running = active_ff;
               rsp_valid_in           = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= vps_pkg::ST_FILL;
         ff_on_ff     <= 1'b0;
         demo_ff      <= 1'b0;
         fill_addr_ff <= '0;
         ptr_ff       <= '0;
         active_ff    <= 1'b0;
         tick_ff      <= 8'd0;
         on_ff        <= 1'b0;
         level_ff     <= 8'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_addr_ff <= fill_addr_in;
         ptr_ff       <= ptr_in;
         active_ff    <= active_in;
         tick_ff      <= tick_in;
         on_ff        <= on_in;
         level_ff     <= level_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_if.valid && csr_if.ready) begin
            case (csr_if.payload.reg_index)
               vps_pkg::CSR_FORCE_FEEDBACK: ff_on_ff <= csr_if.payload.reg_data;
               vps_pkg::CSR_DEMO_PLAYBACK:  demo_ff  <= csr_if.payload.reg_data;
               default: begin
               end
            endcase
         end
      end
      budget_ff    <= budget_in;
      arg_delay_ff <= arg_delay_in;
      rsp_ff       <= rsp_in;
   end

endmodule

`default_nettype wire
